>>> rtl/render_ahead_latency_tracker_unit_assert.svh
// Assertion macros used by the checker module
`ifndef RENDER_AHEAD_LATENCY_TRACKER_UNIT_ASSERT_SVH
`define RENDER_AHEAD_LATENCY_TRACKER_UNIT_ASSERT_SVH

// overlapping implication, checked on the same edge
`define RALA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked on the following edge
`define RALA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rala_pkg.sv
// Types and constants of the render-ahead latency tracker
package rala_pkg;

    localparam int LAT_W      = 24;
    localparam int LEAD_W     = 20;
    localparam int PERIOD_W   = 24;
    localparam int MARGIN_W   = 20;
    localparam int ALLOW_W    = 20;
    localparam int MAXAH_W    = 24;
    localparam int FALL_W     = 20;
    localparam int SUM_W      = 26;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 48;

    localparam logic [MARGIN_W-1:0] MARGIN_RST    = 20'd20000;
    localparam logic [ALLOW_W-1:0]  ALLOWANCE_RST = 20'd30000;
    localparam logic [MAXAH_W-1:0]  MAX_AHEAD_RST = 24'd500000;
    localparam logic [FALL_W-1:0]   FALL_STEP_RST = 20'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MARGIN    = 2'd0,
        REG_ALLOWANCE = 2'd1,
        REG_MAX_AHEAD = 2'd2,
        REG_FALL_STEP = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } op_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_CALC1 = 6'b000100,
        ST_CALC2 = 6'b001000,
        ST_CALC3 = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

endpackage

>>> rtl/render_ahead_latency_tracker_unit.sv
// Render-ahead latency tracker: sliding window maximum with limited decay
//
// Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser. s_tuser selects
// a sample (0) or a clear (1). A sample is written to a ring memory of WINDOW
// entries, then the valid entries are read back one per cycle through the
// memory's single read port to find the maximum. Three arithmetic steps form
// the need, clamp it and update the ahead value. One result word leaves on
// m_tvalid/m_tready/m_tdata for every input word.
// A sample's time grows with fill, the number of valid entries (WINDOW once
// the window is full); a clear skips the scan and the arithmetic steps.
// One word is in work at a time; s_tready is high only while idle.
// The result sits in an output register; the next word is taken while it
// waits, but its result is held back until the receiver takes the first.
// Configuration words on cfg_valid/cfg_ready are always taken and should be
// sent only while idle.
// Reset empties the window, zeroes ahead and restores the register defaults;
// the ring memory itself is not cleared.
module render_ahead_latency_tracker_unit #(
    parameter int WINDOW = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // latency [23:0], present_lead [43:24], frame_period [67:44], zero pad
    input  logic [rala_pkg::IN_TDATA_W-1:0]  s_tdata,
    // op [0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // ahead [23:0], window_max [47:24]
    output logic [rala_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rala_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rala_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rala_pkg::*;

    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);
    localparam logic [CW-1:0] FILL_FULL = CW'(WINDOW);
    localparam logic [AW-1:0] SLOT_LAST = AW'(WINDOW - 1);

    logic [LAT_W-1:0] mem [WINDOW];
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    logic [LAT_W-1:0] rd_data_reg;

    state_t state_reg, state_next;

    logic [MARGIN_W-1:0] margin_reg;
    logic [ALLOW_W-1:0]  allowance_reg;
    logic [MAXAH_W-1:0]  max_ahead_reg;
    logic [FALL_W-1:0]   fall_step_reg;

    logic [AW-1:0]       slot_reg, slot_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [LAT_W-1:0]    ahead_reg, ahead_next;
    logic [CW-1:0]       scan_idx_reg, scan_idx_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [LAT_W-1:0]    best_reg, best_next;
    logic [LEAD_W-1:0]   lead_reg, lead_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [SUM_W-1:0]    need_pos_reg, need_pos_next;
    logic [MAXAH_W-1:0]  limit_reg, limit_next;
    logic [LAT_W-1:0]    need_reg, need_next;
    logic [LAT_W-1:0]    res_ahead_reg, res_ahead_next;
    logic [LAT_W-1:0]    res_max_reg, res_max_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic             s_accept;
    logic             out_free;
    logic             issue;
    logic [SUM_W-1:0] sum;
    logic [LAT_W-1:0] lowered;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    assign mem_we    = s_accept && (op_t'(s_tuser) == OP_SAMPLE);
    assign mem_waddr = slot_reg;
    assign mem_raddr = scan_idx_reg[AW-1:0];
    assign issue     = (scan_idx_reg < fill_reg);

    assign sum = SUM_W'(best_reg) + SUM_W'(margin_reg) + SUM_W'(lead_reg);
    assign lowered = ahead_reg - LAT_W'(fall_step_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= s_tdata[LAT_W-1:0];
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        ahead_next     = ahead_reg;
        scan_idx_next  = scan_idx_reg;
        rd_pend_next   = 1'b0;
        best_next      = best_reg;
        lead_next      = lead_reg;
        period_next    = period_reg;
        need_pos_next  = need_pos_reg;
        limit_next     = limit_reg;
        need_next      = need_reg;
        res_ahead_next = res_ahead_reg;
        res_max_next   = res_max_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (op_t'(s_tuser) == OP_CLEAR)
                    begin
                        slot_next      = '0;
                        fill_next      = '0;
                        ahead_next     = '0;
                        res_ahead_next = '0;
                        res_max_next   = '0;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        slot_next     = (slot_reg == SLOT_LAST) ? '0 : slot_reg + AW'(1);
                        fill_next     = (fill_reg == FILL_FULL) ? fill_reg
                                                                : fill_reg + CW'(1);
                        lead_next     = s_tdata[LAT_W +: LEAD_W];
                        period_next   = s_tdata[LAT_W+LEAD_W +: PERIOD_W];
                        scan_idx_next = '0;
                        best_next     = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rd_pend_reg && (rd_data_reg > best_reg))
                begin
                    best_next = rd_data_reg;
                end
                if (issue)
                begin
                    rd_pend_next  = 1'b1;
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                else if (!rd_pend_reg)
                begin
                    state_next = ST_CALC1;
                end
            end
            ST_CALC1:
            begin
                need_pos_next = (sum > SUM_W'(allowance_reg))
                              ? sum - SUM_W'(allowance_reg) : '0;
                limit_next    = ((period_reg != '0) && (period_reg < max_ahead_reg))
                              ? period_reg : max_ahead_reg;
                state_next    = ST_CALC2;
            end
            ST_CALC2:
            begin
                need_next  = (need_pos_reg > SUM_W'(limit_reg))
                           ? limit_reg : need_pos_reg[LAT_W-1:0];
                state_next = ST_CALC3;
            end
            ST_CALC3:
            begin
                if (need_reg >= ahead_reg)
                begin
                    ahead_next = need_reg;
                end
                else if ((ahead_reg > LAT_W'(fall_step_reg)) && (lowered > need_reg))
                begin
                    ahead_next = lowered;
                end
                else
                begin
                    ahead_next = need_reg;
                end
                res_ahead_next = ahead_next;
                res_max_next   = best_reg;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {res_max_reg, res_ahead_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            ahead_reg     <= '0;
            scan_idx_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            margin_reg    <= MARGIN_RST;
            allowance_reg <= ALLOWANCE_RST;
            max_ahead_reg <= MAX_AHEAD_RST;
            fall_step_reg <= FALL_STEP_RST;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            ahead_reg     <= ahead_next;
            scan_idx_reg  <= scan_idx_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_MARGIN:    margin_reg    <= cfg_data[MARGIN_W-1:0];
                    REG_ALLOWANCE: allowance_reg <= cfg_data[ALLOW_W-1:0];
                    REG_MAX_AHEAD: max_ahead_reg <= cfg_data[MAXAH_W-1:0];
                    REG_FALL_STEP: fall_step_reg <= cfg_data[FALL_W-1:0];
                    default:       margin_reg    <= margin_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        lead_reg      <= lead_next;
        period_reg    <= period_next;
        need_pos_reg  <= need_pos_next;
        limit_reg     <= limit_next;
        need_reg      <= need_next;
        res_ahead_reg <= res_ahead_next;
        res_max_reg   <= res_max_next;
        out_data_reg  <= out_data_next;
    end

endmodule

>>> rtl/rala_checker.sv
// Port checker for the render-ahead latency tracker, bound to the top level
`include "render_ahead_latency_tracker_unit_assert.svh"

module rala_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [rala_pkg::OUT_TDATA_W-1:0] m_tdata
);
    // one word in work at a time
    `RALA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready,
        "input taken again right after a word was accepted")

    // no result in the cycle after an accept
    `RALA_ASSERT_NEXT(a_no_instant_result, clk, rst_n, s_tvalid && s_tready,
        !$rose(m_tvalid), "result appeared one cycle after accept")

    `RALA_ASSERT_NEXT(a_out_valid_holds, clk, rst_n, m_tvalid && !m_tready, m_tvalid,
        "result word dropped while stalled")

    `RALA_ASSERT_NEXT(a_out_data_holds, clk, rst_n, m_tvalid && !m_tready,
        $stable(m_tdata), "result word changed while stalled")

endmodule

bind render_ahead_latency_tracker_unit rala_checker u_rala_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> bench/render_ahead_latency_tracker_unit_tb.sv
// Self-checking testbench of the render-ahead latency tracker, with its own predictor
module render_ahead_latency_tracker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rala_pkg::*;

    localparam int WINDOW = 32;
    localparam int WIN_AW = $clog2(WINDOW);
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        op_t                 op;
        logic [LAT_W-1:0]    lat;
        logic [LEAD_W-1:0]   lead;
        logic [PERIOD_W-1:0] period;
    } sample_t;

    typedef struct packed {
        logic [MAXAH_W-1:0] ahead;
        logic [LAT_W-1:0]   peak;
    } tracker_out_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    sample_t      pending_samples[$];
    tracker_out_t expected_updates[$];

    logic [MARGIN_W-1:0] margin_reg    = MARGIN_RST;
    logic [ALLOW_W-1:0]  allowance_reg = ALLOWANCE_RST;
    logic [MAXAH_W-1:0]  max_ahead_reg = MAX_AHEAD_RST;
    logic [FALL_W-1:0]   fall_reg      = FALL_STEP_RST;
    logic [LAT_W-1:0]    win_lat [WINDOW];
    int                  win_slot = 0;
    int                  win_fill = 0;
    logic [MAXAH_W-1:0]  ahead_now = '0;

    bit word_taken = 1'b0;
    int error_count = 0;
    int results_seen = 0;
    int burst_left = 1;
    int gap_left = 0;
    int hold_left = 0;
    int next_hold_at = 150;
    int stall_mode = 0;
    int mode_left = 0;

    render_ahead_latency_tracker_unit #(
        .WINDOW(WINDOW)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic tracker_out_t advance_tracker(input op_t op,
                                                     input logic [LAT_W-1:0] lat,
                                                     input logic [LEAD_W-1:0] lead,
                                                     input logic [PERIOD_W-1:0] period);
        tracker_out_t res;
        logic [LAT_W-1:0] peak;
        logic [MAXAH_W-1:0] limit;
        longint need;
        longint lowered;
        res = '0;
        if (op == OP_CLEAR)
        begin
            win_slot = 0;
            win_fill = 0;
            ahead_now = '0;
            return res;
        end
        win_lat[WIN_AW'(win_slot)] = lat;
        win_slot = (win_slot + 1) % WINDOW;
        if (win_fill < WINDOW)
            win_fill++;
        peak = '0;
        for (int i = 0; i < win_fill; i++)
            if (win_lat[WIN_AW'(i)] > peak)
                peak = win_lat[WIN_AW'(i)];
        need = longint'(peak) + longint'(margin_reg) + longint'(lead)
             - longint'(allowance_reg);
        limit = max_ahead_reg;
        if (period != '0 && period < limit)
            limit = period;
        if (need < 0)
            need = 0;
        if (need > longint'(limit))
            need = longint'(limit);
        if (need >= longint'(ahead_now))
            ahead_now = need[MAXAH_W-1:0];
        else
        begin
            lowered = longint'(ahead_now) - longint'(fall_reg);
            ahead_now = (lowered > need) ? lowered[MAXAH_W-1:0] : need[MAXAH_W-1:0];
        end
        res.ahead = ahead_now;
        res.peak = peak;
        return res;
    endfunction

    task automatic add_sample(input op_t op, input logic [LAT_W-1:0] lat,
                              input logic [LEAD_W-1:0] lead,
                              input logic [PERIOD_W-1:0] period);
        sample_t it;
        it.op = op;
        it.lat = lat;
        it.lead = lead;
        it.period = period;
        pending_samples.push_back(it);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || expected_updates.size() != 0);
    endtask

    // monitor: predict on every input word, check every result word
    always @(posedge clk)
    begin
        tracker_out_t want;
        word_taken = rst_n && s_tvalid && s_tready;
        if (word_taken)
            expected_updates.push_back(advance_tracker(op_t'(s_tuser), s_tdata[23:0],
                                                       s_tdata[43:24], s_tdata[67:44]));
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_updates.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result word %h", m_tdata);
            end
            else
            begin
                want = expected_updates.pop_front();
                if (m_tdata[23:0] !== want.ahead || m_tdata[47:24] !== want.peak)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("result %0d: ahead exp %0d got %0d, window_max exp %0d got %0d",
                                 results_seen, want.ahead, m_tdata[23:0],
                                 want.peak, m_tdata[47:24]);
                end
            end
        end
    end

    // driver: bursts of words with random gaps, valid held until taken
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || word_taken))
        begin
            if (s_tvalid)
                void'(pending_samples.pop_front());
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {4'b0, pending_samples[0].period, pending_samples[0].lead,
                            pending_samples[0].lat};
                s_tuser <= pending_samples[0].op;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left--;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: stall pattern of its own, with long hold-offs now and then
    always @(negedge clk)
    begin
        if (results_seen >= next_hold_at)
        begin
            hold_left = LONG_HOLD;
            next_hold_at += 900;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(32, 256);
            end
            else
                mode_left--;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 9) >= 3);
                default: m_tready <= ($urandom_range(0, 9) >= 8);
            endcase
        end
    end

    initial
    begin
        cfg_reg_t reg_sel;
        logic [CFG_DATA_W-1:0] val;
        sample_t it;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_sample(OP_SAMPLE, 24'd0, 20'd0, 24'd0);
        add_sample(OP_SAMPLE, 24'hFFFFFF, 20'hFFFFF, 24'd0);
        add_sample(OP_SAMPLE, 24'd100000, 20'd0, 24'd0);
        add_sample(OP_SAMPLE, 24'd1000, 20'd5000, 24'd1);
        add_sample(OP_SAMPLE, 24'd1000, 20'd0, 24'hFFFFFF);
        add_sample(OP_SAMPLE, 24'd50000, 20'd1000, 24'd166833);
        add_sample(OP_CLEAR, 24'hFFFFFF, 20'hFFFFF, 24'hFFFFFF);
        add_sample(OP_SAMPLE, 24'd5000, 20'd0, 24'd0);
        add_sample(OP_SAMPLE, 24'd200000, 20'd10000, 24'd0);
        add_sample(OP_CLEAR, 24'd0, 20'd0, 24'd0);
        add_sample(OP_SAMPLE, 24'd300000, 20'hFFFFF, 24'd0);
        add_sample(OP_CLEAR, 24'h5A5A5A, 20'hA5A5A, 24'h3C3C3C);
        add_sample(OP_SAMPLE, 24'd400000, 20'd0, 24'd0);
        add_sample(OP_SAMPLE, 24'd1000, 20'd0, 24'd100000);
        add_sample(OP_SAMPLE, 24'd1000, 20'd0, 24'd388500);
        add_sample(OP_SAMPLE, 24'd0, 20'd0, 24'd10000000);
        add_sample(OP_SAMPLE, 24'd10000000, 20'd1000000, 24'd10000000);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                wait_drained();
                reg_sel = reg_sel.first();
                repeat (reg_sel.num())
                begin
                    case (ph)
                        1: val = '0;
                        2: val = (reg_sel == REG_MAX_AHEAD) ? 24'hFFFFFF : 24'h0FFFFF;
                        3: case (reg_sel)
                               REG_MARGIN:    val = 24'h0FFFFF;
                               REG_MAX_AHEAD: val = 24'hFFFFFF;
                               default:       val = '0;
                           endcase
                        4: case (reg_sel)
                               REG_ALLOWANCE: val = 24'h0FFFFF;
                               REG_MAX_AHEAD: val = CFG_DATA_W'($urandom_range(0, 24'hFFFFFF));
                               REG_FALL_STEP: val = 24'd1;
                               default:       val = '0;
                           endcase
                        5: case (reg_sel)
                               REG_MAX_AHEAD: val = CFG_DATA_W'($urandom_range(100000, 1000000));
                               REG_FALL_STEP: val = CFG_DATA_W'($urandom_range(0, 5000));
                               default:       val = CFG_DATA_W'($urandom_range(0, 50000));
                           endcase
                        default: val = (reg_sel == REG_MAX_AHEAD)
                                     ? CFG_DATA_W'($urandom_range(0, 24'hFFFFFF))
                                     : CFG_DATA_W'($urandom_range(0, 20'hFFFFF));
                    endcase
                    @(negedge clk);
                    cfg_valid <= 1'b1;
                    cfg_index <= reg_sel;
                    cfg_data <= val;
                    do
                        @(posedge clk);
                    while (!cfg_ready);
                    case (reg_sel)
                        REG_MARGIN:    margin_reg = val[MARGIN_W-1:0];
                        REG_ALLOWANCE: allowance_reg = val[ALLOW_W-1:0];
                        REG_MAX_AHEAD: max_ahead_reg = val[MAXAH_W-1:0];
                        REG_FALL_STEP: fall_reg = val[FALL_W-1:0];
                    endcase
                    reg_sel = reg_sel.next();
                end
                @(negedge clk);
                cfg_valid <= 1'b0;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                it.op = ($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_SAMPLE;
                case ($urandom_range(0, 7))
                    4:       it.lat = LAT_W'($urandom_range(0, 2000));
                    5:       it.lat = LAT_W'($urandom_range(0, 24'hFFFFFF));
                    6:       it.lat = LAT_W'($urandom_range(1000000, 10000000));
                    7:       it.lat = 24'hFFFFFF - LAT_W'($urandom_range(0, 3));
                    default: it.lat = LAT_W'($urandom_range(0, 300000));
                endcase
                case ($urandom_range(0, 3))
                    0:       it.lead = '0;
                    1:       it.lead = LEAD_W'($urandom_range(0, 20'hFFFFF));
                    2:       it.lead = 20'hFFFFF;
                    default: it.lead = LEAD_W'($urandom_range(0, 60000));
                endcase
                case ($urandom_range(0, 4))
                    0:       it.period = '0;
                    1:       it.period = PERIOD_W'($urandom_range(1, 100));
                    2:       it.period = PERIOD_W'($urandom_range(0, 24'hFFFFFF));
                    default: it.period = PERIOD_W'($urandom_range(100000, 700000));
                endcase
                pending_samples.push_back(it);
            end
        end

        wait_drained();
        repeat (WINDOW + 16) @(posedge clk);
        if (error_count == 0 && expected_updates.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
